// ===== rtl/psmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmd_pkg: shared types and constants
// Formats and field widths for the segment distance block.
// ----------------------------------------------------------------------------
package psmd_pkg;
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int DSQ_W     = 64;
	localparam logic [DSQ_W-1:0] DSQ_MAX = '1;

	typedef struct packed {
		logic signed [COORD_W-1:0] query_x;
		logic signed [COORD_W-1:0] query_y;
		logic signed [COORD_W-1:0] query_z;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
		logic [COORD_W-1:0]        inv_len_sq;
		logic                      first_seg;
		logic                      last_seg;
	} seg_t;

	typedef struct packed {
		logic [COORD_W-1:0] min_distance;
		logic               overflowed;
	} res_t;
endpackage

// ===== rtl/psmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmd_if: valid/ready channel
// Carries one beat of a payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface psmd_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/point_segment_min_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_min_distance: running minimum point-to-segment distance
// Folds 3D segments against a query point and reports the root of the minimum.
// ----------------------------------------------------------------------------
// Usage:
//  seg_in carries one segment per beat with the query point, start, direction,
//  reciprocal squared length and first/last marks. first_seg restarts the
//  running minimum; last_seg makes one beat on res_out after the segment.
//  One shared multiplier runs the dot product, projection, foot point and
//  squared distance, then the minimum update and a return to idle: seg_in
//  is not ready from an accepting edge until that return, so the block takes
//  no new segment while one is still being folded. A last segment adds the
//  bit-serial square root and a load of the output register before seg_in
//  takes the next segment. A result waits in the output register until taken
//  while further segments are folded in; if the next result is ready before
//  then, the block holds it and takes no segment meanwhile.
//  Reset clears the running minimum to all ones and drops any pending beat.
// ----------------------------------------------------------------------------
module point_segment_min_distance
	import psmd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	psmd_if.sink    seg_in,
	psmd_if.source  res_out
);
	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_SEG  = 2'd1;
	localparam logic [1:0] T_SQRT = 2'd2;
	localparam logic [1:0] T_LOAD = 2'd3;

	logic [1:0]       st_q;
	logic             last_q;
	logic             core_done;
	logic [DSQ_W-1:0] best;
	logic             sq_start;
	logic             sq_done;
	logic [31:0]      root;
	res_t             res_q;
	logic             out_valid_q;
	logic             load;
	logic             acc;

	assign seg_in.ready = (st_q == T_IDLE);
	assign acc          = seg_in.valid && seg_in.ready;
	assign sq_start     = (st_q == T_SEG) && core_done && last_q;
	assign load         = (st_q == T_LOAD) && (!out_valid_q || res_out.ready);

	psmd_core u_core (
		.clk(clk), .arst_n(arst_n), .start(acc), .seg(seg_in.data),
		.done(core_done), .best(best)
	);

	psmd_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(best),
		.done(sq_done), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				T_IDLE: if (acc) begin
					st_q   <= T_SEG;
					last_q <= seg_in.data.last_seg;
				end
				T_SEG: if (core_done) st_q <= last_q ? T_SQRT : T_IDLE;
				T_SQRT: if (sq_done) st_q <= T_LOAD;
				T_LOAD: if (load) st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
			// hold the beat until taken; a new one may replace it in the same cycle
			if (load) out_valid_q <= 1'b1;
			else if (res_out.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.min_distance <= root;
			res_q.overflowed   <= (best == DSQ_MAX);
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data  = res_q;
endmodule

// ===== rtl/psmd_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmd_isqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module psmd_isqrt
	import psmd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DSQ_W-1:0] value,
	output logic             done,
	output logic [31:0]      root
);
	logic [DSQ_W-1:0] rem_q;
	logic [31:0]      res_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [DSQ_W-1:0] trial;
	logic [DSQ_W-1:0] rnext;

	// test (2*res + (1 << bit)) << bit against remainder, restoring
	always_comb begin
		rnext = rem_q;
		trial = {res_q, 32'd0} >> 0;
		trial = ({32'd0, res_q} << (cnt_q + 6'd1)) | (64'd1 << {cnt_q, 1'b0});
		if (rem_q >= trial) rnext = rem_q - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd31;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= rnext;
			res_q <= (rem_q >= trial) ? (res_q | (32'd1 << cnt_q[4:0])) : res_q;
		end
	end

	assign root = res_q;
endmodule

// ===== rtl/psmd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmd_core: sequenced segment distance datapath
// One shared 34x34 signed multiplier steps through dot product, projection,
// foot point and squared distance; then the running minimum is updated.
// ----------------------------------------------------------------------------
module psmd_core
	import psmd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  seg_t             seg,
	output logic             done,
	output logic [DSQ_W-1:0] best
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DOT  = 4'd1;
	localparam logic [3:0] S_UL   = 4'd2;
	localparam logic [3:0] S_UH   = 4'd3;
	localparam logic [3:0] S_FOOT = 4'd4;
	localparam logic [3:0] S_DSQ  = 4'd5;
	localparam logic [3:0] S_MIN  = 4'd6;

	logic [3:0]          st_q;
	logic [1:0]          k_q;
	seg_t                seg_q;
	logic signed [67:0]  dot_q;
	logic [97:0]         uf_q;
	logic [33:0]         u_q;
	logic                near_q;
	logic                clip_q;
	logic signed [33:0]  foot_q [3];
	logic [67:0]         acc_q;
	logic [DSQ_W-1:0]    best_q;

	logic signed [33:0]  ma, mb;
	logic signed [67:0]  prod;
	logic signed [32:0]  qv, sv, dv;
	logic signed [33:0]  ev;
	logic signed [33:0]  pv;
	logic [33:0]         emag;
	logic [67:0]         dmag;

	always_comb begin
		case (k_q)
			2'd0: begin qv = 33'(seg_q.query_x); sv = 33'(seg_q.start_x); dv = 33'(seg_q.dir_x); end
			2'd1: begin qv = 33'(seg_q.query_y); sv = 33'(seg_q.start_y); dv = 33'(seg_q.dir_y); end
			default: begin qv = 33'(seg_q.query_z); sv = 33'(seg_q.start_z); dv = 33'(seg_q.dir_z); end
		endcase
		pv   = near_q ? 34'(sv) : foot_q[k_q];
		ev   = 34'(qv) - pv;
		emag = ev[33] ? 34'(-ev) : 34'(ev);
		dmag = dot_q[67] ? 68'd0 : 68'(dot_q);
		ma = '0;
		mb = '0;
		case (st_q)
			S_DOT: begin ma = 34'(qv - sv); mb = 34'(dv); end
			S_UL:  begin ma = {2'b0, dmag[31:0]}; mb = {2'b0, seg_q.inv_len_sq}; end
			S_UH:  begin ma = {2'b0, dmag[63:32]}; mb = {2'b0, seg_q.inv_len_sq}; end
			S_FOOT: begin ma = 34'(u_q[FRAC_BITS:0]); mb = 34'(dv); end
			S_DSQ: begin ma = {1'b0, emag[32:0]}; mb = {1'b0, emag[32:0]}; end
			default: begin ma = '0; mb = '0; end
		endcase
		prod = ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			k_q    <= '0;
			done   <= 1'b0;
			best_q <= DSQ_MAX;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: if (start) begin
					st_q <= S_DOT;
					k_q  <= '0;
					if (seg.first_seg) best_q <= DSQ_MAX;
				end
				S_DOT: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) st_q <= S_UL;
				end
				S_UL: st_q <= S_UH;
				S_UH: st_q <= S_FOOT;
				S_FOOT: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) st_q <= S_DSQ;
				end
				S_DSQ: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) st_q <= S_MIN;
				end
				S_MIN: begin
					if (acc_q[67:64] == 4'd0 && acc_q[63:0] < best_q) best_q <= acc_q[63:0];
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (start) begin
				seg_q <= seg;
				dot_q <= '0;
				acc_q <= '0;
			end
			S_DOT: dot_q <= dot_q + prod;
			S_UL: uf_q <= 98'(prod[63:0]);
			S_UH: begin
				// the clamped dot product reaches at most bit 64: its top word is one bit
				uf_q   <= uf_q + ({34'd0, prod[63:0]} << 32)
					+ ({66'd0, (dmag[64] ? seg_q.inv_len_sq : 32'd0)} << 64);
			end
			S_FOOT: begin
				foot_q[k_q] <= clip_q ? 34'(sv) + 34'(dv)
					: 34'(sv) + 34'(prod >>> FRAC_BITS);
			end
			S_DSQ: acc_q <= acc_q + 68'(prod);
			default: ;
		endcase
		if (st_q == S_UH) begin
			near_q <= dot_q[67] && (seg_q.inv_len_sq != '0);
		end
	end

	// projection parameter u and end clip, taken from the full product
	always_comb begin
		clip_q = (66'(uf_q[97:2*FRAC_BITS]) > 66'(1 << FRAC_BITS));
		u_q    = 34'(uf_q[97:2*FRAC_BITS]);
	end

	assign best = best_q;
endmodule
